// ===== hw/rtl/cpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    // field and datapath widths
    localparam int unsigned TimeW = 32;
    localparam int unsigned FracW = 16;
    localparam int unsigned DvdW  = 48;
    localparam int unsigned ArgW  = DvdW + 1;
    localparam int unsigned CntW  = 6;

    localparam logic [TimeW-1:0] CycleLenReset = 32'd65536;

    // iteration counts of the shared divider
    localparam logic [CntW-1:0] PhaseIters = 6'd48;
    localparam logic [CntW-1:0] StepIters  = 6'd33;
    localparam logic [CntW-1:0] FracIters  = 6'd16;

    typedef enum logic [2:0] {
        MODE_TICK         = 3'd0,
        MODE_SEEK         = 3'd1,
        MODE_SET_PHASE    = 3'd2,
        MODE_CLEAR        = 3'd3,
        MODE_SET_PAUSE    = 3'd4,
        MODE_TOGGLE_PAUSE = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        DIV_HOLD = 2'd0,
        DIV_LOAD = 2'd1,
        DIV_STEP = 2'd2
    } t_div_op;

    typedef struct packed {
        t_div_op op;
        logic    neg;
    } t_div_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/cycle_phase_timer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  beat contents
// in        sink       i_mode, i_time_step, i_phase_value, i_pause_value
// out       source     o_elapsed_time, o_phase_fraction, o_is_paused
// cfg       sink       i_cfg_cycle_length
//
// one beat at a time through a shared restoring divider, one bit per cycle:
// tick and seek reduce elapsed modulo the length, set phase multiplies first,
// then the fraction is divided out; paused tick and other commands divide only,
// a zero length skips the modulo; a length write reduces elapsed (zeroes it at 0)
// synchronous active-low reset: length 65536, elapsed 0, running
// the result sits in an output register, so a stalled out channel only blocks
// the next beat once that beat's result is ready

module cycle_phase_timer_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [2:0]                i_mode,
    input  wire logic [cpt_pkg::TimeW-1:0] i_time_step,
    input  wire logic [cpt_pkg::TimeW-1:0] i_phase_value,
    input  wire logic                      i_pause_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [cpt_pkg::TimeW-1:0] o_elapsed_time,
    output logic      [cpt_pkg::FracW-1:0] o_phase_fraction,
    output logic                           o_is_paused,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [cpt_pkg::TimeW-1:0] i_cfg_cycle_length
);
    import cpt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ABS  = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_FIX  = 7'b0010000,
        S_FRAC = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // control state
    t_state            r_state,     n_state;
    logic [TimeW-1:0]  r_len,       n_len;
    logic [TimeW-1:0]  r_elapsed,   n_elapsed;
    logic              r_paused,    n_paused;
    logic              r_out_valid, n_out_valid;
    logic [CntW-1:0]   r_cnt,       n_cnt;
    logic              r_cfg_op,    n_cfg_op;
    logic              r_is_phase,  n_is_phase;
    logic              r_neg,       n_neg;

    // payload
    logic signed [TimeW-1:0] r_phase, n_phase;
    logic [ArgW-1:0]         r_arg,   n_arg;
    logic [TimeW-1:0]        r_out_elapsed, n_out_elapsed;
    logic [FracW-1:0]        r_out_frac,    n_out_frac;
    logic                    r_out_paused,  n_out_paused;

    // datapath
    t_div_ctl                div_ctl;
    logic [TimeW-1:0]        div_load_rem;
    logic [DvdW-1:0]         div_load_dvd;
    logic [TimeW-1:0]        div_wrapped;
    logic [FracW-1:0]        div_quo;
    logic [ArgW-1:0]         step_sum;
    logic [ArgW-1:0]         arg_mag;
    logic signed [2*TimeW:0] phase_prod;

    cpt_div_unit u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_divisor  (r_len),
        .i_load_rem (div_load_rem),
        .i_load_dvd (div_load_dvd),
        .o_wrapped  (div_wrapped),
        .o_quo      (div_quo)
    );

    // elapsed plus signed step, kept as a wide two's complement value
    assign step_sum = {{(ArgW-TimeW){1'b0}}, r_elapsed}
                    + {{(ArgW-TimeW){i_time_step[TimeW-1]}}, i_time_step};

    // signed fraction times unsigned length, one multiply registered into r_arg
    assign phase_prod = r_phase * $signed({1'b0, r_len});

    assign arg_mag = r_arg[ArgW-1] ? (ArgW'(0) - r_arg) : r_arg;

    assign o_in_ready       = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready      = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_elapsed_time   = r_out_elapsed;
    assign o_phase_fraction = r_out_frac;
    assign o_is_paused      = r_out_paused;

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_elapsed     = r_elapsed;
        n_paused      = r_paused;
        n_out_valid   = r_out_valid;
        n_cnt         = r_cnt;
        n_cfg_op      = r_cfg_op;
        n_is_phase    = r_is_phase;
        n_neg         = r_neg;
        n_phase       = r_phase;
        n_arg         = r_arg;
        n_out_elapsed = r_out_elapsed;
        n_out_frac    = r_out_frac;
        n_out_paused  = r_out_paused;
        div_ctl.op    = DIV_HOLD;
        div_ctl.neg   = r_neg;
        div_load_rem  = r_elapsed;
        div_load_dvd  = '0;

        // output beat taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // new length: reduce the held elapsed into it
                    n_len      = i_cfg_cycle_length;
                    n_cfg_op   = 1'b1;
                    n_is_phase = 1'b0;
                    n_arg      = {{(ArgW-TimeW){1'b0}}, r_elapsed};
                    n_state    = S_ABS;
                end else if (i_in_valid) begin
                    n_cfg_op   = 1'b0;
                    n_is_phase = 1'b0;
                    n_phase    = i_phase_value;
                    // default path: elapsed unchanged unless cleared, go straight to the fraction
                    div_ctl.op = DIV_LOAD;
                    n_cnt      = FracIters;
                    n_state    = S_FRAC;
                    unique case (i_mode)
                        MODE_TICK: begin
                            if (!r_paused) begin
                                div_ctl.op = DIV_HOLD;
                                n_arg      = step_sum;
                                n_state    = S_ABS;
                            end
                        end
                        MODE_SEEK: begin
                            div_ctl.op = DIV_HOLD;
                            n_arg      = step_sum;
                            n_state    = S_ABS;
                        end
                        MODE_SET_PHASE: begin
                            div_ctl.op = DIV_HOLD;
                            n_is_phase = 1'b1;
                            n_state    = S_MUL;
                        end
                        MODE_CLEAR: begin
                            n_elapsed    = '0;
                            div_load_rem = '0;
                        end
                        MODE_SET_PAUSE: begin
                            n_paused = i_pause_value;
                        end
                        MODE_TOGGLE_PAUSE: begin
                            n_paused = ~r_paused;
                        end
                        default: begin
                            // unused codes just report the current state
                        end
                    endcase
                end
            end

            S_MUL: begin
                // arithmetic shift by 16 floors toward minus infinity
                n_arg   = phase_prod[2*TimeW:2*TimeW-ArgW+1];
                n_state = S_ABS;
            end

            S_ABS: begin
                n_neg = r_arg[ArgW-1];
                if (r_len == '0) begin
                    // zero length pins elapsed to zero
                    n_elapsed = '0;
                    if (r_cfg_op) begin
                        n_state = S_IDLE;
                    end else begin
                        div_ctl.op   = DIV_LOAD;
                        div_load_rem = '0;
                        n_cnt        = FracIters;
                        n_state      = S_FRAC;
                    end
                end else begin
                    div_ctl.op   = DIV_LOAD;
                    div_load_rem = '0;
                    if (r_is_phase) begin
                        div_load_dvd = arg_mag[DvdW-1:0];
                        n_cnt        = PhaseIters;
                    end else begin
                        // a step sum fits 33 bits: left-align and run fewer steps
                        div_load_dvd = {arg_mag[StepIters-1:0], {(DvdW-StepIters){1'b0}}};
                        n_cnt        = StepIters;
                    end
                    n_state = S_MOD;
                end
            end

            S_MOD: begin
                div_ctl.op = DIV_STEP;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_state = S_FIX;
                end
            end

            S_FIX: begin
                n_elapsed = div_wrapped;
                if (r_cfg_op) begin
                    n_state = S_IDLE;
                end else begin
                    div_ctl.op   = DIV_LOAD;
                    div_load_rem = div_wrapped;
                    n_cnt        = FracIters;
                    n_state      = S_FRAC;
                end
            end

            S_FRAC: begin
                // elapsed < length, so 16 steps give floor(elapsed * 2^16 / length)
                div_ctl.op = DIV_STEP;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_elapsed = r_elapsed;
                    n_out_frac    = (r_len == '0) ? '0 : div_quo;
                    n_out_paused  = r_paused;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= CycleLenReset;
            r_elapsed   <= '0;
            r_paused    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_cfg_op    <= 1'b0;
            r_is_phase  <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_elapsed   <= n_elapsed;
            r_paused    <= n_paused;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_cfg_op    <= n_cfg_op;
            r_is_phase  <= n_is_phase;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase       <= n_phase;
        r_arg         <= n_arg;
        r_out_elapsed <= n_out_elapsed;
        r_out_frac    <= n_out_frac;
        r_out_paused  <= n_out_paused;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_div_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared restoring divider, one quotient bit per step
module cpt_div_unit (
    input  wire logic                      i_clk,
    input  wire cpt_pkg::t_div_ctl         i_ctl,
    input  wire logic [cpt_pkg::TimeW-1:0] i_divisor,
    input  wire logic [cpt_pkg::TimeW-1:0] i_load_rem,
    input  wire logic [cpt_pkg::DvdW-1:0]  i_load_dvd,
    output logic      [cpt_pkg::TimeW-1:0] o_wrapped,
    output logic      [cpt_pkg::FracW-1:0] o_quo
);
    import cpt_pkg::*;

    logic [TimeW-1:0] r_rem;
    logic [DvdW-1:0]  r_dvd;
    logic [FracW-1:0] r_quo;

    logic [TimeW:0]   shifted;
    logic [TimeW+1:0] sub_a;
    logic [TimeW+1:0] sub_b;
    logic [TimeW+1:0] sub_res;
    logic             fits;

    // one subtractor: trial subtract while stepping, len - rem otherwise
    always_comb begin
        shifted = {r_rem, r_dvd[DvdW-1]};
        if (i_ctl.op == DIV_STEP) begin
            sub_a = {1'b0, shifted};
            sub_b = {2'b00, i_divisor};
        end else begin
            sub_a = {2'b00, i_divisor};
            sub_b = {2'b00, r_rem};
        end
        sub_res = sub_a - sub_b;
        fits    = ~sub_res[TimeW+1];
    end

    // euclidean fixup for a negative dividend
    assign o_wrapped = (i_ctl.neg && (r_rem != '0)) ? sub_res[TimeW-1:0] : r_rem;
    assign o_quo     = r_quo;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            DIV_LOAD: begin
                r_rem <= i_load_rem;
                r_dvd <= i_load_dvd;
            end
            DIV_STEP: begin
                r_dvd <= {r_dvd[DvdW-2:0], 1'b0};
                r_quo <= {r_quo[FracW-2:0], fits};
                if (fits) begin
                    r_rem <= sub_res[TimeW-1:0];
                end else begin
                    r_rem <= shifted[TimeW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/phase_timer_checker.sv =====
`timescale 1ns / 1ps

module phase_timer_checker
    import cpt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic [2:0]              i_mode,
    input  wire logic signed [TimeW-1:0] i_time_step,
    input  wire logic signed [TimeW-1:0] i_phase_value,
    input  wire logic                    i_pause_value,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic [TimeW-1:0]        i_elapsed_time,
    input  wire logic [FracW-1:0]        i_phase_fraction,
    input  wire logic                    i_is_paused,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [TimeW-1:0]        i_cfg_cycle_length,
    output int                           o_pending,
    output int                           o_fail_count
);

    typedef struct packed {
        logic [TimeW-1:0] elapsed;
        logic [FracW-1:0] fraction;
        logic             paused;
    } phase_report_t;

    phase_report_t    expected_reports[$];
    logic [TimeW-1:0] cycle_len;
    logic [TimeW-1:0] elapsed_now;
    logic             paused_now;

    // euclidean modulo into 0 .. cycle_len-1, zero length holds at 0
    function automatic logic [TimeW-1:0] wrap_to_cycle(longint value);
        longint len;
        longint rem;
        len = longint'(cycle_len);
        if (len == 0) return '0;
        rem = value % len;
        if (rem < 0) rem += len;
        return rem[TimeW-1:0];
    endfunction

    function automatic phase_report_t advance_timer(logic [2:0] mode,
                                                    logic signed [TimeW-1:0] step,
                                                    logic signed [TimeW-1:0] phase,
                                                    logic pval);
        phase_report_t   report;
        logic [DvdW-1:0] quotient;
        case (mode)
            MODE_TICK: begin
                if (!paused_now)
                    elapsed_now = wrap_to_cycle(longint'(elapsed_now) + longint'(step));
            end
            MODE_SEEK: begin
                elapsed_now = wrap_to_cycle(longint'(elapsed_now) + longint'(step));
            end
            MODE_SET_PHASE: begin
                // arithmetic shift floors toward minus infinity
                elapsed_now = wrap_to_cycle((longint'(phase) * longint'(cycle_len)) >>> 16);
            end
            MODE_CLEAR:        elapsed_now = '0;
            MODE_SET_PAUSE:    paused_now = pval;
            MODE_TOGGLE_PAUSE: paused_now = ~paused_now;
            default: ;
        endcase
        quotient = '0;
        if (cycle_len != 0)
            quotient = {elapsed_now, {FracW{1'b0}}} / {{(DvdW-TimeW){1'b0}}, cycle_len};
        report.elapsed  = elapsed_now;
        report.fraction = quotient[FracW-1:0];
        report.paused   = paused_now;
        return report;
    endfunction

    always @(posedge i_clk) begin
        phase_report_t want;
        if (!i_rst_n) begin
            cycle_len    = CycleLenReset;
            elapsed_now  = '0;
            paused_now   = 1'b0;
            o_fail_count = 0;
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result beat with none expected, got %h %h %b", $time,
                             i_elapsed_time, i_phase_fraction, i_is_paused);
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_elapsed_time !== want.elapsed) begin
                        $display("%0t: elapsed_time expected %h, got %h", $time,
                                 want.elapsed, i_elapsed_time);
                        o_fail_count++;
                    end
                    if (i_phase_fraction !== want.fraction) begin
                        $display("%0t: phase_fraction expected %h, got %h", $time,
                                 want.fraction, i_phase_fraction);
                        o_fail_count++;
                    end
                    if (i_is_paused !== want.paused) begin
                        $display("%0t: is_paused expected %b, got %b", $time,
                                 want.paused, i_is_paused);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cycle_len   = i_cfg_cycle_length;
                elapsed_now = wrap_to_cycle(longint'(elapsed_now));
            end
            if (i_in_valid && i_in_ready)
                expected_reports.push_back(advance_timer(i_mode, i_time_step,
                                                         i_phase_value, i_pause_value));
        end
        o_pending <= expected_reports.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cpt_pkg::*;

    // mode codes the block does not define, they must leave the state alone
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned PHASE_ITEMS   = 105;
    localparam int unsigned NUM_PHASES    = 7;
    localparam int unsigned SETTLE_CYCLES = 100;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       in_mode;
    logic [TimeW-1:0] in_time_step;
    logic [TimeW-1:0] in_phase_value;
    logic             in_pause_value;
    logic             out_valid;
    logic             out_ready;
    logic [TimeW-1:0] out_elapsed;
    logic [FracW-1:0] out_fraction;
    logic             out_paused;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [TimeW-1:0] cfg_length;

    int               pending_reports;
    int               fail_count;
    int unsigned      cycle_count = 0;
    logic             steady_stream;   // both sides run without gaps while set
    logic [TimeW-1:0] cur_length;      // mirror of the cycle length, for shaping stimulus

    cycle_phase_timer_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_mode             (in_mode),
        .i_time_step        (in_time_step),
        .i_phase_value      (in_phase_value),
        .i_pause_value      (in_pause_value),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_elapsed_time     (out_elapsed),
        .o_phase_fraction   (out_fraction),
        .o_is_paused        (out_paused),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_cycle_length (cfg_length)
    );

    phase_timer_checker u_phase_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_mode             (in_mode),
        .i_time_step        (in_time_step),
        .i_phase_value      (in_phase_value),
        .i_pause_value      (in_pause_value),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_elapsed_time     (out_elapsed),
        .i_phase_fraction   (out_fraction),
        .i_is_paused        (out_paused),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_cycle_length (cfg_length),
        .o_pending          (pending_reports),
        .o_fail_count       (fail_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog, far above the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: a random stall before each beat, none during steady stretches
    initial begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = steady_stream ? 0 : $urandom_range(0, 19);
            repeat (stall) begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // one command beat: optional gap, then hold valid until the block takes it
    task automatic send_cmd(input logic [2:0] mode, input logic [TimeW-1:0] step,
                            input logic [TimeW-1:0] phase, input logic pval);
        int unsigned gap;
        gap = steady_stream ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_mode        = mode;
        in_time_step   = step;
        in_phase_value = phase;
        in_pause_value = pval;
        in_valid       = 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // drop valid and hold off until every result beat has been taken
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        do @(posedge clk); while (pending_reports != 0);
    endtask

    // length writes only happen with the block idle
    task automatic set_cycle_length(input logic [TimeW-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_length = value;
        cfg_valid  = 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid  = 1'b0;
        cur_length = value;
    endtask

    // signed step: full range, small moves, about one cycle, mid range, extremes
    function automatic logic [TimeW-1:0] pick_time_step();
        logic [TimeW-1:0] mag;
        case ($urandom_range(0, 4))
            0: mag = $urandom;
            1: mag = $urandom_range(0, 511) - 256;
            2: mag = cur_length + $urandom_range(0, 2) - 1;
            3: mag = $urandom_range(0, 32'h0003_FFFF);
            default: begin
                case ($urandom_range(0, 3))
                    0: mag = 32'h7FFF_FFFF;
                    1: mag = 32'h8000_0000;
                    2: mag = 32'hFFFF_FFFF;
                    default: mag = '0;
                endcase
            end
        endcase
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // phase fraction: mostly below 32'h0003_0000 in magnitude, some full range and edges
    function automatic logic [TimeW-1:0] pick_phase();
        logic [TimeW-1:0] mag;
        case ($urandom_range(0, 3))
            0: mag = $urandom;
            1: mag = $urandom_range(0, 32'h0001_0000);
            2: mag = $urandom_range(0, 32'h0002_FFFF);
            default: begin
                case ($urandom_range(0, 4))
                    0: mag = 32'h7FFF_FFFF;
                    1: mag = 32'h8000_0000;
                    2: mag = 32'h0000_FFFF;
                    3: mag = 32'h0001_0000;
                    default: mag = 32'h0000_0001;
                endcase
            end
        endcase
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    task automatic send_random_cmd();
        logic [2:0]  mode;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      mode = MODE_TICK;
        else if (pick < 50) mode = MODE_SEEK;
        else if (pick < 68) mode = MODE_SET_PHASE;
        else if (pick < 76) mode = MODE_CLEAR;
        else if (pick < 86) mode = MODE_SET_PAUSE;
        else if (pick < 95) mode = MODE_TOGGLE_PAUSE;
        else if (pick < 98) mode = MODE_SPARE_A;
        else                mode = MODE_SPARE_B;
        send_cmd(mode, pick_time_step(), pick_phase(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [TimeW-1:0] lengths [NUM_PHASES];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_mode        = MODE_TICK;
        in_time_step   = '0;
        in_phase_value = '0;
        in_pause_value = 1'b0;
        cfg_valid      = 1'b0;
        cfg_length     = '0;
        steady_stream  = 1'b0;
        cur_length     = CycleLenReset;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pass at the reset length
        send_cmd(MODE_TICK,         32'h7FFF_FFFF, '0, 1'b0);  // largest forward tick
        send_cmd(MODE_TICK,         32'h8000_0000, '0, 1'b1);  // most negative tick
        send_cmd(MODE_SEEK,         32'hFFFF_FFFF, '0, 1'b0);  // rewind by one lsb
        send_cmd(MODE_SEEK,         '0,            '0, 1'b1);
        send_cmd(MODE_SET_PHASE,    '0, 32'h7FFF_FFFF, 1'b0);
        send_cmd(MODE_SET_PHASE,    '0, 32'h8000_0000, 1'b0);
        send_cmd(MODE_SET_PHASE,    '0, 32'hFFFF_FFFF, 1'b0);  // negative product floors
        send_cmd(MODE_SET_PHASE,    '0, 32'h0000_8000, 1'b0);  // half way
        send_cmd(MODE_SET_PHASE,    '0, 32'h0001_0000, 1'b0);  // whole cycle wraps to 0
        send_cmd(MODE_SEEK,         32'h0000_4321, '0, 1'b0);
        send_cmd(MODE_CLEAR,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(MODE_SET_PAUSE,    '0,            '0, 1'b1);
        send_cmd(MODE_TICK,         32'h0001_2345, '0, 1'b0);  // paused tick is ignored
        send_cmd(MODE_SEEK,         32'hFFFF_0000, '0, 1'b0);  // seek still moves when paused
        send_cmd(MODE_TOGGLE_PAUSE, '0,            '0, 1'b0);
        send_cmd(MODE_TOGGLE_PAUSE, '0,            '0, 1'b1);
        send_cmd(MODE_SET_PAUSE,    32'hFFFF_FFFF, '0, 1'b0);
        send_cmd(MODE_SPARE_A,      32'h1234_5678, 32'h8765_4321, 1'b1);
        send_cmd(MODE_SPARE_B,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_cmd(MODE_TICK,         32'h0000_0001, '0, 1'b0);
        send_cmd(MODE_TICK,         32'hFFFF_FFFF, '0, 1'b0);

        // length settings: smallest, largest, zero, short, mid, anything, back to reset
        lengths[0] = 32'h0000_0001;
        lengths[1] = 32'hFFFF_FFFF;
        lengths[2] = '0;
        lengths[3] = $urandom_range(2, 5000);
        lengths[4] = (32'($urandom_range(1, 40)) << 16) + $urandom_range(0, 32'hFFFF);
        lengths[5] = $urandom;
        lengths[6] = CycleLenReset;

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_cycle_length(lengths[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate idle-heavy stretches with back-to-back ones
                if (n % 35 == 0) steady_stream = ($urandom_range(0, 3) == 0);
                // hold the sender once mid-phase until the pipe is empty
                if (p == 3 && n == 50) wait_drained();
                send_random_cmd();
            end
        end

        steady_stream = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_div_unit.sv
hw/rtl/cycle_phase_timer_unit.sv
bench/phase_timer_checker.sv
bench/testbench.sv
